>>> hdl/ordered_list_engine_core_macros.svh
// Assertion macros shared by the RTL of the ordered list engine.
`ifndef ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`define ORDERED_LIST_ENGINE_CORE_MACROS_SVH

// Condition must never be true outside reset.
`define OLE_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the same cycle.
`define OLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/ole_pkg.sv
package ole_pkg;

    // Operation codes carried by a command transaction.
    typedef enum logic [3:0] {
        FN_APPEND   = 4'd0,
        FN_FRONT    = 4'd1,
        FN_INSERT   = 4'd2,
        FN_DEL_HEAD = 4'd3,
        FN_DEL_AT   = 4'd4,
        FN_SEARCH   = 4'd5,
        FN_STATS    = 4'd6,
        FN_REVERSE  = 4'd7,
        FN_SORT     = 4'd8,
        FN_TRAVERSE = 4'd9
    } func_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // What every cell of the chain does.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT,
        CELL_SORT
    } cell_op_t;

    // Control broadcast from the sequencer to the cells.
    typedef struct packed {
        cell_op_t op;
        logic     phase;
    } cell_ctl_t;

endpackage

>>> hdl/ole_cell.sv
module ole_cell #(
    parameter int IW    = 6,
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  ole_pkg::cell_ctl_t ctl,
    input  logic [IW-1:0]      mark,
    input  logic signed [31:0] value,
    input  logic signed [31:0] left,
    input  logic signed [31:0] right,
    input  logic signed [31:0] head,
    output logic signed [31:0] data
);
    import ole_pkg::*;

    localparam logic [IW:0] ME = (IW+1)'(INDEX);

    logic [IW:0]        lim;
    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               lower;
    logic               upper;

    assign lim = {1'b0, mark};

    // Odd-even transposition: this cell is the low or high side of a pair.
    assign lower = (ME[0] == ctl.phase) && (ME + 1'b1 < lim);
    assign upper = (INDEX > 0) && (ME[0] != ctl.phase) && (ME < lim);

    // Select the next content from the neighbors, the new value or the head.
    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            CELL_HOLD: data_next = data_reg;
            CELL_INS:
            begin
                if (ME == lim)
                    data_next = value;
                else if (ME > lim)
                    data_next = left;
            end
            CELL_DEL:
            begin
                if (ME >= lim)
                    data_next = right;
            end
            CELL_ROT:
            begin
                if (ME + 1'b1 < lim)
                    data_next = right;
                else if (ME + 1'b1 == lim)
                    data_next = head;
            end
            CELL_SORT:
            begin
                if (lower && (data_reg > right))
                    data_next = right;
                else if (upper && (left > data_reg))
                    data_next = left;
            end
            default: data_next = data_reg;
        endcase
    end

    // Payload register, no reset needed.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> hdl/ordered_list_engine_core.sv
// Channel   Handshake            Payload
// command   start / busy         func, value, position
// result    done (no back-pressure) status, element, found_position, entry_count,
//                                total, largest, smallest, in_order, last
//
// Append, front, insert, delete and unknown codes raise done in the cycle after they are accepted; busy stays low.
// Search, stats and traverse rotate the cell chain once, so that each entry passes the head.
// Reverse rotates ever shorter leading parts of the list; sort runs odd-even exchange phases.
// Traverse emits one result per cycle; results cannot be stalled.
// Reset clears the length and the sequencer; cell contents are left undefined.
`include "ordered_list_engine_core_macros.svh"

module ordered_list_engine_core #(
    parameter int DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         func,
    input  logic signed [31:0] value,
    input  logic [5:0]         position,
    output logic               done,
    output logic [2:0]         status,
    output logic signed [31:0] element,
    output logic [5:0]         found_position,
    output logic [5:0]         entry_count,
    output logic signed [36:0] total,
    output logic signed [31:0] largest,
    output logic signed [31:0] smallest,
    output logic               in_order,
    output logic               last
);
    import ole_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = ((LW > 6) ? LW : 6) + 1;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_REV, S_SORT} state_t;

    state_t             state_reg;
    func_t              func_reg;
    logic [LW-1:0]      len_reg;
    logic [LW-1:0]      cnt_reg;
    logic signed [31:0] value_reg;
    logic               hit_reg;
    logic [LW-1:0]      fpos_reg;
    logic signed [36:0] sum_reg;
    logic signed [31:0] max_reg;
    logic signed [31:0] min_reg;
    logic               ord_reg;

    logic               done_reg;
    status_t            status_reg;
    logic signed [31:0] element_reg;
    logic [5:0]         found_reg;
    logic [5:0]         count_reg;
    logic signed [36:0] total_reg;
    logic signed [31:0] largest_reg;
    logic signed [31:0] smallest_reg;
    logic               in_order_reg;
    logic               last_reg;

    logic signed [31:0] cells [DEPTH];
    cell_ctl_t          ctl;
    logic [LW-1:0]      mark;
    func_t              fn;
    logic               accept;
    logic               full;
    logic               empty;
    logic               ins_bad;
    logic               del_bad;
    logic [CW-1:0]      pos_w;
    logic [CW-1:0]      len_w;
    logic [LW-1:0]      idx;
    logic               at_end;
    logic signed [31:0] h;
    logic               hit_now;
    logic [LW-1:0]      fpos_now;
    logic signed [36:0] sum_now;
    logic signed [31:0] max_now;
    logic signed [31:0] min_now;
    logic               ord_now;

    assign fn      = func_t'(func);
    assign accept  = start && (state_reg == S_IDLE);
    assign pos_w   = CW'(position);
    assign len_w   = CW'(len_reg);
    assign full    = (len_reg >= LW'(DEPTH));
    assign empty   = (len_reg == '0);
    assign ins_bad = (pos_w == '0) || (pos_w > len_w + 1'b1);
    assign del_bad = (pos_w == '0) || (pos_w > len_w);
    assign idx     = LW'(pos_w - 1'b1);
    assign at_end  = (CW'(cnt_reg) + 1'b1 == len_w);
    assign h       = cells[0];

    // Per-step walk accumulators, valid while rotating.
    always_comb
    begin
        hit_now  = hit_reg || (h == value_reg);
        fpos_now = hit_reg ? fpos_reg : cnt_reg;
        sum_now  = ((cnt_reg == '0) ? 37'sd0 : sum_reg) + 37'(h);
        max_now  = ((cnt_reg == '0) || (h > max_reg)) ? h : max_reg;
        min_now  = ((cnt_reg == '0) || (h < min_reg)) ? h : min_reg;
        ord_now  = ((cnt_reg == '0) ? 1'b1 : ord_reg) && !(!at_end && (h > cells[1]));
    end

    // Command to the cell chain.
    always_comb
    begin
        ctl.op    = CELL_HOLD;
        ctl.phase = cnt_reg[0];
        mark      = len_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if ((fn == FN_APPEND) && !full)
                    begin
                        ctl.op = CELL_INS;
                        mark   = len_reg;
                    end
                    else if ((fn == FN_FRONT) && !full)
                    begin
                        ctl.op = CELL_INS;
                        mark   = '0;
                    end
                    else if ((fn == FN_INSERT) && !full && !ins_bad)
                    begin
                        ctl.op = CELL_INS;
                        mark   = idx;
                    end
                    else if ((fn == FN_DEL_HEAD) && !empty)
                    begin
                        ctl.op = CELL_DEL;
                        mark   = '0;
                    end
                    else if ((fn == FN_DEL_AT) && !empty && !del_bad)
                    begin
                        ctl.op = CELL_DEL;
                        mark   = idx;
                    end
                    else
                    begin
                        ctl.op = CELL_HOLD;
                    end
                end
            end
            S_WALK: ctl.op = CELL_ROT;
            S_REV:
            begin
                ctl.op = CELL_ROT;
                mark   = cnt_reg;
            end
            S_SORT: ctl.op = CELL_SORT;
            default: ctl.op = CELL_HOLD;
        endcase
    end

    // The chain of cells holding the list, head at cell 0.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        ole_cell #(
            .IW    (LW),
            .INDEX (g)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .mark  (mark),
            .value (value),
            .left  (cells[(g == 0) ? 0 : g - 1]),
            .right (cells[(g == DEPTH - 1) ? g : g + 1]),
            .head  (cells[0]),
            .data  (cells[g])
        );
    end

    // Sequencer and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            cnt_reg      <= '0;
            done_reg     <= 1'b0;
            func_reg     <= FN_APPEND;
            value_reg    <= '0;
            hit_reg      <= 1'b0;
            fpos_reg     <= '0;
            sum_reg      <= '0;
            max_reg      <= '0;
            min_reg      <= '0;
            ord_reg      <= 1'b0;
            status_reg   <= ST_OK;
            element_reg  <= '0;
            found_reg    <= '0;
            count_reg    <= '0;
            total_reg    <= '0;
            largest_reg  <= '0;
            smallest_reg <= '0;
            in_order_reg <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg     <= fn;
                        value_reg    <= value;
                        cnt_reg      <= '0;
                        hit_reg      <= 1'b0;
                        element_reg  <= '0;
                        found_reg    <= '0;
                        total_reg    <= '0;
                        largest_reg  <= '0;
                        smallest_reg <= '0;
                        in_order_reg <= 1'b0;
                        last_reg     <= 1'b1;
                        status_reg   <= ST_OK;
                        count_reg    <= 6'(len_reg);
                        done_reg     <= 1'b1;
                        unique case (fn)
                            FN_APPEND, FN_FRONT, FN_INSERT:
                            begin
                                if (full)
                                    status_reg <= ST_FULL;
                                else if ((fn == FN_INSERT) && ins_bad)
                                    status_reg <= ST_BADPOS;
                                else
                                begin
                                    len_reg   <= len_reg + 1'b1;
                                    count_reg <= 6'(len_reg + 1'b1);
                                end
                            end
                            FN_DEL_HEAD, FN_DEL_AT:
                            begin
                                if (empty)
                                    status_reg <= ST_EMPTY;
                                else if ((fn == FN_DEL_AT) && del_bad)
                                    status_reg <= ST_BADPOS;
                                else
                                begin
                                    len_reg   <= len_reg - 1'b1;
                                    count_reg <= 6'(len_reg - 1'b1);
                                end
                            end
                            FN_SEARCH, FN_STATS, FN_TRAVERSE:
                            begin
                                if (empty)
                                    status_reg <= ST_EMPTY;
                                else
                                begin
                                    done_reg  <= 1'b0;
                                    state_reg <= S_WALK;
                                end
                            end
                            FN_REVERSE:
                            begin
                                if (empty)
                                    status_reg <= ST_EMPTY;
                                else if (len_reg != LW'(1))
                                begin
                                    done_reg  <= 1'b0;
                                    cnt_reg   <= len_reg;
                                    state_reg <= S_REV;
                                end
                            end
                            FN_SORT:
                            begin
                                if (len_reg > LW'(1))
                                begin
                                    done_reg  <= 1'b0;
                                    state_reg <= S_SORT;
                                end
                            end
                            default: status_reg <= ST_OK;
                        endcase
                    end
                end
                S_WALK:
                begin
                    cnt_reg  <= cnt_reg + 1'b1;
                    hit_reg  <= hit_now;
                    fpos_reg <= fpos_now;
                    sum_reg  <= sum_now;
                    max_reg  <= max_now;
                    min_reg  <= min_now;
                    ord_reg  <= ord_now;
                    if (func_reg == FN_TRAVERSE)
                    begin
                        done_reg    <= 1'b1;
                        element_reg <= h;
                        last_reg    <= at_end;
                    end
                    if (at_end)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                        last_reg  <= 1'b1;
                        if (func_reg == FN_SEARCH)
                        begin
                            status_reg <= hit_now ? ST_OK : ST_NOTFOUND;
                            found_reg  <= hit_now ? 6'(fpos_now + 1'b1) : 6'd0;
                        end
                        else if (func_reg == FN_STATS)
                        begin
                            total_reg    <= sum_now;
                            largest_reg  <= max_now;
                            smallest_reg <= min_now;
                            in_order_reg <= ord_now;
                        end
                    end
                end
                S_REV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == LW'(2))
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                S_SORT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (at_end)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign element        = element_reg;
    assign found_position = found_reg;
    assign entry_count    = count_reg;
    assign total          = total_reg;
    assign largest        = largest_reg;
    assign smallest       = smallest_reg;
    assign in_order       = in_order_reg;
    assign last           = last_reg;

    // The length never exceeds the chain.
    `OLE_ASSERT_NEVER(a_len_bound, clk, rst_n, len_reg > LW'(DEPTH))
    // A result that is not the last one comes while a walk is still running.
    `OLE_ASSERT_IMPLY(a_mid_busy, clk, rst_n, done && !last, busy)
    // Traverse results follow each other without gaps.
    `OLE_ASSERT_NEXT(a_trav_run, clk, rst_n, done && !last, done)
    // An operation that raises busy never changes the length.
    `OLE_ASSERT_NEXT(a_len_hold, clk, rst_n, busy, len_reg == $past(len_reg))

endmodule
